### design/life_pkg.sv
// life_pkg: shared constants for the b3/s23 cell automaton block
// operation codes, register indexes, rule counts and default sizes
// no dependencies
`default_nettype none

package life_pkg;

    // default storage size
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    // configuration registers
    localparam int          CFG_W      = 7;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;
    localparam logic        REG_GRID_WIDTH  = 1'b0;
    localparam logic        REG_GRID_HEIGHT = 1'b1;

    // stream word layout
    localparam int FUNC_W  = 2;
    localparam int COORD_W = 6;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_STEP  = 2'd2;

    // neighbor count width and rule thresholds
    localparam int NCNT_W = 4;
    localparam logic [NCNT_W-1:0] BIRTH_COUNT  = 4'd3;
    localparam logic [NCNT_W-1:0] SURVIVE_LOW  = 4'd2;
    localparam logic [NCNT_W-1:0] SURVIVE_HIGH = 4'd3;

endpackage

`default_nettype wire

### design/life_automaton_generation.sv
// life_automaton_generation: cell grid with b3/s23 generation stepping
// row memory, three-row window and one shared row-update unit
// depends on life_pkg
`default_nettype none

//  channel    direction  content
//  s_axis     in         word: func, column, row, set_alive
//  m_axis     out        word: cell_alive, step_done
//  apb        in/out     grid_width at 0x0, grid_height at 0x4
//
// cell write or read: row read, row update, result stage
// generation step: the row memory, with one read and one write port, is
// read once and written once per used row, one row per cycle
// reset clears all cells at once through per-row valid bits
// one item at a time; a held result does not block taking the next word

module life_automaton_generation #(
    parameter int MAX_WIDTH  = life_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = life_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // stream in
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // [1:0] func, [7:2] column, [13:8] row, [14] set_alive, [15] zero
    input  wire logic [life_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // stream out
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // [0] cell_alive, [1] step_done, [7:2] zero
    output logic [life_pkg::OUT_TDATA_W-1:0]        o_m_axis_tdata,
    // configuration
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [2:0]                         paddr,
    input  wire logic [31:0]                        pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready
);
    import life_pkg::*;

    localparam int RA  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CA  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int UWB = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
    localparam int UHB = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CELL = 2'd1;
    localparam logic [1:0] ST_STEP = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    // config registers
    logic [CFG_W-1:0] r_grid_width;
    logic [CFG_W-1:0] r_grid_height;

    // control state
    logic [1:0]   r_state, n_state;
    logic [UHB-1:0] r_cnt, n_cnt;
    logic         r_out_vld;
    logic         r_res_alive, n_res_alive;
    logic         r_res_done, n_res_done;
    logic         r_out_alive, r_out_done;

    // latched item
    logic [FUNC_W-1:0]  r_func;
    logic [COORD_W-1:0] r_col;
    logic [COORD_W-1:0] r_row;
    logic               r_val;

    // row window
    logic [MAX_WIDTH-1:0] r_up, n_up;
    logic [MAX_WIDTH-1:0] r_mid, n_mid;

    // row memory with per-row valid bits
    logic [MAX_WIDTH-1:0] r_mem [MAX_HEIGHT];
    logic [MAX_HEIGHT-1:0] r_row_valid;
    logic [MAX_WIDTH-1:0] r_rdq;
    logic                 r_rdq_vld;
    logic                 rd_en, wr_en;
    logic [RA-1:0]        rd_addr, wr_addr;
    logic [MAX_WIDTH-1:0] wr_data;

    // derived signals
    logic [FUNC_W-1:0]  in_func;
    logic [COORD_W-1:0] in_col, in_row;
    logic               in_val, in_acc, in_inside;
    logic [UWB-1:0]     used_w;
    logic [UHB-1:0]     used_h;
    logic [MAX_WIDTH-1:0] w_mask, row_q, incoming, life_row;
    logic [MAX_WIDTH+1:0] pad_up, pad_mid, pad_dn;
    logic [NCNT_W-1:0]  ncnt;
    logic               fin_go;
    logic               cfg_wr;

    // input word fields
    assign in_func = i_s_axis_tdata[FUNC_W-1:0];
    assign in_col  = i_s_axis_tdata[FUNC_W+COORD_W-1:FUNC_W];
    assign in_row  = i_s_axis_tdata[FUNC_W+2*COORD_W-1:FUNC_W+COORD_W];
    assign in_val  = i_s_axis_tdata[FUNC_W+2*COORD_W];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;

    // used grid size, clamped to storage
    assign used_w = (UWB'(r_grid_width) > UWB'(MAX_WIDTH)) ? UWB'(MAX_WIDTH)
                                                           : UWB'(r_grid_width);
    assign used_h = (UHB'(r_grid_height) > UHB'(MAX_HEIGHT)) ? UHB'(MAX_HEIGHT)
                                                             : UHB'(r_grid_height);
    assign in_inside = (UWB'(in_col) < used_w) && (UHB'(in_row) < used_h);

    always_comb begin
        for (int c = 0; c < MAX_WIDTH; c++) begin
            w_mask[c] = (UWB'(c) < used_w);
        end
    end

    // read data, rows never written read as dead
    assign row_q = r_rdq_vld ? r_rdq : '0;
    assign incoming = (r_cnt < used_h) ? row_q : '0;

    // shared row-update unit: neighbor count and rule for every column
    assign pad_up  = {1'b0, r_up & w_mask, 1'b0};
    assign pad_mid = {1'b0, r_mid & w_mask, 1'b0};
    assign pad_dn  = {1'b0, incoming & w_mask, 1'b0};

    always_comb begin
        ncnt = '0;
        for (int c = 0; c < MAX_WIDTH; c++) begin
            ncnt = NCNT_W'(pad_up[c]) + NCNT_W'(pad_up[c+1]) + NCNT_W'(pad_up[c+2])
                 + NCNT_W'(pad_mid[c]) + NCNT_W'(pad_mid[c+2])
                 + NCNT_W'(pad_dn[c]) + NCNT_W'(pad_dn[c+1]) + NCNT_W'(pad_dn[c+2]);
            if (pad_mid[c+1]) begin
                life_row[c] = (ncnt >= SURVIVE_LOW) && (ncnt <= SURVIVE_HIGH);
            end else begin
                life_row[c] = (ncnt == BIRTH_COUNT);
            end
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_up        = r_up;
        n_mid       = r_mid;
        n_res_alive = r_res_alive;
        n_res_done  = r_res_done;
        rd_en       = 1'b0;
        rd_addr     = RA'(r_row);
        wr_en       = 1'b0;
        wr_addr     = RA'(r_row);
        wr_data     = row_q;
        fin_go      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    priority if ((in_func == FUNC_WRITE || in_func == FUNC_READ)
                                 && in_inside) begin
                        rd_en   = 1'b1;
                        rd_addr = RA'(in_row);
                        n_state = ST_CELL;
                    end else if (in_func == FUNC_STEP) begin
                        rd_en   = 1'b1;
                        rd_addr = '0;
                        n_cnt   = '0;
                        n_up    = '0;
                        n_mid   = '0;
                        n_state = ST_STEP;
                    end else begin
                        // outside the grid or unused code
                        n_res_alive = 1'b0;
                        n_res_done  = 1'b0;
                        n_state     = ST_FIN;
                    end
                end
            end
            ST_CELL: begin
                n_res_done = 1'b0;
                if (r_func == FUNC_WRITE) begin
                    wr_en               = 1'b1;
                    wr_data[CA'(r_col)] = r_val;
                    n_res_alive         = r_val;
                end else begin
                    n_res_alive = row_q[CA'(r_col)];
                end
                n_state = ST_FIN;
            end
            ST_STEP: begin
                // row r_cnt arrives, row r_cnt - 1 is rewritten
                if (r_cnt != '0) begin
                    wr_en   = 1'b1;
                    wr_addr = RA'(r_cnt - 1'b1);
                    wr_data = (life_row & w_mask) | (r_mid & ~w_mask);
                end
                n_up  = r_mid;
                n_mid = incoming;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == used_h) begin
                    n_res_alive = 1'b0;
                    n_res_done  = 1'b1;
                    n_state     = ST_FIN;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = RA'(r_cnt + 1'b1);
                end
            end
            ST_FIN: begin
                if (!r_out_vld || i_m_axis_tready) begin
                    fin_go  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_vld   <= 1'b0;
            r_row_valid <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (fin_go) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            if (wr_en) begin
                r_row_valid[wr_addr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_up        <= n_up;
        r_mid       <= n_mid;
        r_res_alive <= n_res_alive;
        r_res_done  <= n_res_done;
        if (in_acc) begin
            r_func <= in_func;
            r_col  <= in_col;
            r_row  <= in_row;
            r_val  <= in_val;
        end
        if (fin_go) begin
            r_out_alive <= r_res_alive;
            r_out_done  <= r_res_done;
        end
    end

    // row memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdq     <= r_mem[rd_addr];
            r_rdq_vld <= r_row_valid[rd_addr];
        end
    end

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= CFG_RESET;
            r_grid_height <= CFG_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_GRID_WIDTH) begin
                r_grid_width <= pwdata[CFG_W-1:0];
            end else begin
                r_grid_height <= pwdata[CFG_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_GRID_WIDTH) ? {{(32-CFG_W){1'b0}}, r_grid_width}
                                                 : {{(32-CFG_W){1'b0}}, r_grid_height};

    // output word
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W-2){1'b0}}, r_out_done, r_out_alive};

endmodule

`default_nettype wire
